// ===== sv/arm_tool_forward_kinematics_core_defines.svh =====
// assertion macros for the forward kinematics core
`ifndef ARM_TOOL_FORWARD_KINEMATICS_CORE_DEFINES_SVH
`define ARM_TOOL_FORWARD_KINEMATICS_CORE_DEFINES_SVH

// same-cycle implication
`define AFTK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define AFTK_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== sv/aftk_pkg.sv =====
package aftk_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES          = 24;

    localparam int JOINT_W  = 18;
    localparam int ANG_W    = 20;
    localparam int TRIG_W   = 32;
    localparam int Z_W      = 33;
    localparam int RED_W    = 38;
    localparam int TURN_W   = 5;
    localparam int CFG_W    = 18;
    localparam int ROT_W    = 18;
    localparam int POS_W    = 19;
    localparam int Q_W      = 34;
    localparam int PACC_W   = 56;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 3;

    localparam int ANGLE_SHIFT  = 16;
    localparam int TRIG_FRAC    = 30;
    localparam int ROT_SHIFT    = 14;
    localparam int REDUCE_STEPS = 8;
    localparam int ROT_LIMIT    = 65536;
    localparam int POS_LIMIT    = 131072;

    localparam longint ANG_PI      = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    localparam logic [IDX_W-1:0] REG_TOOL_LENGTH     = 3'd0;
    localparam logic [IDX_W-1:0] REG_BASE_HEIGHT     = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHOULDER_OFFSET = 3'd2;
    localparam logic [IDX_W-1:0] REG_WRIST_OFFSET    = 3'd3;
    localparam logic [IDX_W-1:0] REG_FLANGE_OFFSET   = 3'd4;
    localparam logic [IDX_W-1:0] REG_UPPER_ARM       = 3'd5;
    localparam logic [IDX_W-1:0] REG_FOREARM         = 3'd6;

    localparam logic signed [CFG_W-1:0] RST_TOOL_LENGTH     = 18'sd14418;
    localparam logic signed [CFG_W-1:0] RST_BASE_HEIGHT     = 18'sd9509;
    localparam logic signed [CFG_W-1:0] RST_SHOULDER_OFFSET = -18'sd8008;
    localparam logic signed [CFG_W-1:0] RST_WRIST_OFFSET    = 18'sd6947;
    localparam logic signed [CFG_W-1:0] RST_FLANGE_OFFSET   = 18'sd7497;
    localparam logic signed [CFG_W-1:0] RST_UPPER_ARM       = 18'sd28115;
    localparam logic signed [CFG_W-1:0] RST_FOREARM         = 18'sd26968;

    typedef logic signed [ANG_W-1:0]  angle_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [Z_W-1:0]    z_t;
    typedef logic signed [CFG_W-1:0]  cfg_t;
    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [PACC_W-1:0] pacc_t;

    function automatic z_t atan_q30(input int i);
        z_t r;
        case (i)
            0:       r = 33'sd843314856;
            1:       r = 33'sd497837829;
            2:       r = 33'sd263043837;
            3:       r = 33'sd133525159;
            4:       r = 33'sd67021687;
            5:       r = 33'sd33543516;
            6:       r = 33'sd16775851;
            7:       r = 33'sd8388437;
            8:       r = 33'sd4194283;
            9:       r = 33'sd2097149;
            10:      r = 33'sd1048576;
            11:      r = 33'sd524288;
            12:      r = 33'sd262144;
            13:      r = 33'sd131072;
            14:      r = 33'sd65536;
            15:      r = 33'sd32768;
            16:      r = 33'sd16384;
            17:      r = 33'sd8192;
            18:      r = 33'sd4096;
            19:      r = 33'sd2048;
            20:      r = 33'sd1024;
            21:      r = 33'sd512;
            22:      r = 33'sd256;
            23:      r = 33'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // angle bound above which a further half turn is taken off
    function automatic logic signed [ANG_W:0] reduce_thr(input int j);
        return (ANG_W+1)'((ANG_HALF_PI + longint'(j) * ANG_PI) >>> ANGLE_SHIFT);
    endfunction

    function automatic logic signed [RED_W-1:0] pi_mult(input logic signed [TURN_W-1:0] k);
        return RED_W'(longint'(k) * ANG_PI);
    endfunction

endpackage

// ===== sv/aftk_cordic.sv =====
module aftk_cordic
    import aftk_pkg::*;
#(
    parameter int ITER = CORDIC_ITERATIONS_DEF
)
(
    input  logic   clk,
    input  angle_t angle,
    output trig_t  sin_val,
    output trig_t  cos_val
);

    angle_t                    angle_reg;
    logic signed [TURN_W-1:0]  turns_reg;
    logic signed [TURN_W-1:0]  turns_next;
    logic [TURN_W-2:0]         above;
    logic [TURN_W-2:0]         below;
    logic signed [RED_W-1:0]   z_wide;

    z_t    z_reg    [0:ITER];
    trig_t x_reg    [0:ITER];
    trig_t y_reg    [0:ITER];
    logic  flip_reg [0:ITER];
    trig_t sin_reg;
    trig_t cos_reg;

    // half turns to take off
    always_comb
    begin
        above = '0;
        below = '0;
        for (int j = 0; j < REDUCE_STEPS; j++)
        begin
            if (angle > reduce_thr(j))
            begin
                above = above + 1'b1;
            end
            if (angle < -reduce_thr(j))
            begin
                below = below + 1'b1;
            end
        end
        turns_next = $signed({1'b0, above}) - $signed({1'b0, below});
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle;
        turns_reg <= turns_next;
    end

    assign z_wide = (RED_W'(angle_reg) <<< ANGLE_SHIFT) - pi_mult(turns_reg);

    always_ff @(posedge clk)
    begin
        z_reg[0]    <= z_wide[Z_W-1:0];
        x_reg[0]    <= TRIG_W'(CORDIC_GAIN);
        y_reg[0]    <= '0;
        flip_reg[0] <= turns_reg[0];
    end

    generate
        for (genvar i = 0; i < ITER; i++)
        begin : g_iter
            always_ff @(posedge clk)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        sin_reg <= flip_reg[ITER] ? -y_reg[ITER] : y_reg[ITER];
        cos_reg <= flip_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== sv/arm_tool_forward_kinematics_core.sv =====
// an accepted start reaches done through the joint-sum input stage, the CORDIC pipelines and the product and sum stages
// throughput: one transaction per cycle, busy stays low
// the CORDIC iteration stages set the depth, one iteration per stage
// done is high for one cycle per result, the receiver cannot stall
// rst_n is asynchronous active low: clears the pipeline valids and reloads the link registers
`include "arm_tool_forward_kinematics_core_defines.svh"

module arm_tool_forward_kinematics_core
    import aftk_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [JOINT_W-1:0] joint1_angle,
    input  logic signed [JOINT_W-1:0] joint2_angle,
    input  logic signed [JOINT_W-1:0] joint3_angle,
    input  logic signed [JOINT_W-1:0] joint4_angle,
    input  logic signed [JOINT_W-1:0] joint5_angle,
    input  logic signed [JOINT_W-1:0] joint6_angle,
    output logic                      done,
    output logic signed [ROT_W-1:0]   rot_00,
    output logic signed [ROT_W-1:0]   rot_01,
    output logic signed [ROT_W-1:0]   rot_02,
    output logic signed [POS_W-1:0]   pos_x,
    output logic signed [ROT_W-1:0]   rot_10,
    output logic signed [ROT_W-1:0]   rot_11,
    output logic signed [ROT_W-1:0]   rot_12,
    output logic signed [POS_W-1:0]   pos_y,
    output logic signed [ROT_W-1:0]   rot_20,
    output logic signed [ROT_W-1:0]   rot_21,
    output logic signed [ROT_W-1:0]   rot_22,
    output logic signed [POS_W-1:0]   pos_z,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    localparam int CORDIC_LAT = CORDIC_ITERATIONS + 3;
    localparam int TOTAL_LAT  = CORDIC_LAT + 7;
    localparam int PROD_W     = Q_W + TRIG_W;
    localparam int D_W        = CFG_W + 1;

    function automatic q_t mulq(input q_t a, input trig_t b);
        logic signed [PROD_W-1:0] p;
        p = a * b;
        p = p + (PROD_W'(1) <<< (TRIG_FRAC - 1));
        return Q_W'(p >>> TRIG_FRAC);
    endfunction

    function automatic pacc_t pmul(input logic signed [D_W-1:0] d, input q_t v);
        pacc_t p;
        p = d * v;
        return p;
    endfunction

    function automatic logic signed [ROT_W-1:0] rot_sat(input q_t r);
        logic signed [Q_W:0] t;
        t = ((Q_W+1)'(r) + ((Q_W+1)'(1) <<< (ROT_SHIFT - 1))) >>> ROT_SHIFT;
        if (t > ROT_LIMIT)
        begin
            t = (Q_W+1)'(ROT_LIMIT);
        end
        else if (t < -ROT_LIMIT)
        begin
            t = -(Q_W+1)'(ROT_LIMIT);
        end
        return ROT_W'(t);
    endfunction

    function automatic logic signed [POS_W-1:0] pos_sat(input pacc_t v);
        pacc_t t;
        t = (v + (PACC_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
        if (t > POS_LIMIT)
        begin
            t = PACC_W'(POS_LIMIT);
        end
        else if (t < -POS_LIMIT)
        begin
            t = -PACC_W'(POS_LIMIT);
        end
        return POS_W'(t);
    endfunction

    // configuration registers
    cfg_t tool_length_reg;
    cfg_t base_height_reg;
    cfg_t shoulder_offset_reg;
    cfg_t wrist_offset_reg;
    cfg_t flange_offset_reg;
    cfg_t upper_arm_length_reg;
    cfg_t forearm_length_reg;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;
    logic [IDX_W-1:0] rd_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign rd_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tool_length_reg      <= RST_TOOL_LENGTH;
            base_height_reg      <= RST_BASE_HEIGHT;
            shoulder_offset_reg  <= RST_SHOULDER_OFFSET;
            wrist_offset_reg     <= RST_WRIST_OFFSET;
            flange_offset_reg    <= RST_FLANGE_OFFSET;
            upper_arm_length_reg <= RST_UPPER_ARM;
            forearm_length_reg   <= RST_FOREARM;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_TOOL_LENGTH:     tool_length_reg      <= pwdata[CFG_W-1:0];
                REG_BASE_HEIGHT:     base_height_reg      <= pwdata[CFG_W-1:0];
                REG_SHOULDER_OFFSET: shoulder_offset_reg  <= pwdata[CFG_W-1:0];
                REG_WRIST_OFFSET:    wrist_offset_reg     <= pwdata[CFG_W-1:0];
                REG_FLANGE_OFFSET:   flange_offset_reg    <= pwdata[CFG_W-1:0];
                REG_UPPER_ARM:       upper_arm_length_reg <= pwdata[CFG_W-1:0];
                REG_FOREARM:         forearm_length_reg   <= pwdata[CFG_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (rd_idx)
            REG_TOOL_LENGTH:     prdata = DATA_W'(tool_length_reg);
            REG_BASE_HEIGHT:     prdata = DATA_W'(base_height_reg);
            REG_SHOULDER_OFFSET: prdata = DATA_W'(shoulder_offset_reg);
            REG_WRIST_OFFSET:    prdata = DATA_W'(wrist_offset_reg);
            REG_FLANGE_OFFSET:   prdata = DATA_W'(flange_offset_reg);
            REG_UPPER_ARM:       prdata = DATA_W'(upper_arm_length_reg);
            REG_FOREARM:         prdata = DATA_W'(forearm_length_reg);
            default:             prdata = '0;
        endcase
    end

    logic signed [D_W-1:0] tool_d;
    assign tool_d = D_W'(tool_length_reg) + D_W'(flange_offset_reg);

    // input stage: joint sums
    logic   s0_vld_reg;
    angle_t q1_reg;
    angle_t q2_reg;
    angle_t q23_reg;
    angle_t q234_reg;
    angle_t q5_reg;
    angle_t q6_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk)
    begin
        q1_reg   <= ANG_W'(joint1_angle);
        q2_reg   <= ANG_W'(joint2_angle);
        q23_reg  <= ANG_W'(joint2_angle) + ANG_W'(joint3_angle);
        q234_reg <= ANG_W'(joint2_angle) + ANG_W'(joint3_angle) + ANG_W'(joint4_angle);
        q5_reg   <= ANG_W'(joint5_angle);
        q6_reg   <= ANG_W'(joint6_angle);
    end

    // sine and cosine
    trig_t s1, c1, t2s, t2c, u, v, sp, cp, s5, c5, s6, c6;

    aftk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_1
    (
        .clk     (clk),
        .angle   (q1_reg),
        .sin_val (s1),
        .cos_val (c1)
    );

    aftk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_2
    (
        .clk     (clk),
        .angle   (q2_reg),
        .sin_val (t2s),
        .cos_val (t2c)
    );

    aftk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_23
    (
        .clk     (clk),
        .angle   (q23_reg),
        .sin_val (u),
        .cos_val (v)
    );

    aftk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_234
    (
        .clk     (clk),
        .angle   (q234_reg),
        .sin_val (sp),
        .cos_val (cp)
    );

    aftk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_5
    (
        .clk     (clk),
        .angle   (q5_reg),
        .sin_val (s5),
        .cos_val (c5)
    );

    aftk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_6
    (
        .clk     (clk),
        .angle   (q6_reg),
        .sin_val (s6),
        .cos_val (c6)
    );

    logic [CORDIC_LAT-1:0] cvld_reg;
    logic p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg, p5_vld_reg, p6_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            cvld_reg   <= '0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start && !busy;
            cvld_reg   <= {cvld_reg[CORDIC_LAT-2:0], s0_vld_reg};
            p1_vld_reg <= cvld_reg[CORDIC_LAT-1];
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
        end
    end

    // stage 1: products of the trig values
    q_t a_reg, b_reg, g_reg, h_reg, k_reg;
    q_t sps6_reg, spc6_reg, cps6_reg, cpc6_reg;
    q_t c1sp_reg, s1sp_reg, c1c2_reg, s1c2_reg, c1c23_reg, s1c23_reg;
    q_t r8_p1_reg, s1c5_reg, c1c5_reg;
    trig_t c1_p1_reg, s1_p1_reg, c6_p1_reg, s6_p1_reg, cp_p1_reg, t2c_p1_reg, v_p1_reg;

    always_ff @(posedge clk)
    begin
        a_reg      <= mulq(Q_W'(cp), c5);
        b_reg      <= mulq(Q_W'(sp), c5);
        g_reg      <= mulq(Q_W'(s5), c6);
        h_reg      <= mulq(Q_W'(s5), s6);
        k_reg      <= mulq(Q_W'(cp), s5);
        sps6_reg   <= mulq(Q_W'(sp), s6);
        spc6_reg   <= mulq(Q_W'(sp), c6);
        cps6_reg   <= mulq(Q_W'(cp), s6);
        cpc6_reg   <= mulq(Q_W'(cp), c6);
        c1sp_reg   <= mulq(Q_W'(c1), sp);
        s1sp_reg   <= mulq(Q_W'(s1), sp);
        c1c2_reg   <= mulq(Q_W'(c1), t2s);
        s1c2_reg   <= mulq(Q_W'(s1), t2s);
        c1c23_reg  <= mulq(Q_W'(c1), u);
        s1c23_reg  <= mulq(Q_W'(s1), u);
        r8_p1_reg  <= -mulq(Q_W'(sp), s5);
        s1c5_reg   <= mulq(Q_W'(s1), c5);
        c1c5_reg   <= mulq(Q_W'(c1), c5);
        c1_p1_reg  <= c1;
        s1_p1_reg  <= s1;
        c6_p1_reg  <= c6;
        s6_p1_reg  <= s6;
        cp_p1_reg  <= cp;
        t2c_p1_reg <= t2c;
        v_p1_reg   <= v;
    end

    // stage 2: second level products
    q_t ac6_reg, as6_reg, bc6_reg, bs6_reg, c1k_reg, s1k_reg;
    q_t c1g_reg, s1g_reg, c1h_reg, s1h_reg;
    q_t sps6_p2_reg, spc6_p2_reg, cps6_p2_reg, cpc6_p2_reg, s1c5_p2_reg, c1c5_p2_reg;
    q_t r8_p2_reg, c1sp_p2_reg, s1sp_p2_reg, c1c2_p2_reg, s1c2_p2_reg;
    q_t c1c23_p2_reg, s1c23_p2_reg;
    trig_t cp_p2_reg, t2c_p2_reg, v_p2_reg, c1_p2_reg, s1_p2_reg;

    always_ff @(posedge clk)
    begin
        ac6_reg      <= mulq(a_reg, c6_p1_reg);
        as6_reg      <= mulq(a_reg, s6_p1_reg);
        bc6_reg      <= mulq(b_reg, c6_p1_reg);
        bs6_reg      <= mulq(b_reg, s6_p1_reg);
        c1k_reg      <= mulq(k_reg, c1_p1_reg);
        s1k_reg      <= mulq(k_reg, s1_p1_reg);
        c1g_reg      <= mulq(g_reg, c1_p1_reg);
        s1g_reg      <= mulq(g_reg, s1_p1_reg);
        c1h_reg      <= mulq(h_reg, c1_p1_reg);
        s1h_reg      <= mulq(h_reg, s1_p1_reg);
        sps6_p2_reg  <= sps6_reg;
        spc6_p2_reg  <= spc6_reg;
        cps6_p2_reg  <= cps6_reg;
        cpc6_p2_reg  <= cpc6_reg;
        s1c5_p2_reg  <= s1c5_reg;
        c1c5_p2_reg  <= c1c5_reg;
        r8_p2_reg    <= r8_p1_reg;
        c1sp_p2_reg  <= c1sp_reg;
        s1sp_p2_reg  <= s1sp_reg;
        c1c2_p2_reg  <= c1c2_reg;
        s1c2_p2_reg  <= s1c2_reg;
        c1c23_p2_reg <= c1c23_reg;
        s1c23_p2_reg <= s1c23_reg;
        cp_p2_reg    <= cp_p1_reg;
        t2c_p2_reg   <= t2c_p1_reg;
        v_p2_reg     <= v_p1_reg;
        c1_p2_reg    <= c1_p1_reg;
        s1_p2_reg    <= s1_p1_reg;
    end

    // stage 3: wrist sums
    q_t e_reg, f_reg, r2_p3_reg, r5_p3_reg, r6_p3_reg, r7_p3_reg;
    q_t c1g_p3_reg, s1g_p3_reg, c1h_p3_reg, s1h_p3_reg, r8_p3_reg;
    q_t c1sp_p3_reg, s1sp_p3_reg, c1c2_p3_reg, s1c2_p3_reg, c1c23_p3_reg, s1c23_p3_reg;
    trig_t cp_p3_reg, t2c_p3_reg, v_p3_reg, c1_p3_reg, s1_p3_reg;

    always_ff @(posedge clk)
    begin
        e_reg        <= sps6_p2_reg + ac6_reg;
        f_reg        <= spc6_p2_reg - as6_reg;
        r2_p3_reg    <= c1k_reg + s1c5_p2_reg;
        r5_p3_reg    <= s1k_reg - c1c5_p2_reg;
        r6_p3_reg    <= cps6_p2_reg - bc6_reg;
        r7_p3_reg    <= cpc6_p2_reg + bs6_reg;
        c1g_p3_reg   <= c1g_reg;
        s1g_p3_reg   <= s1g_reg;
        c1h_p3_reg   <= c1h_reg;
        s1h_p3_reg   <= s1h_reg;
        r8_p3_reg    <= r8_p2_reg;
        c1sp_p3_reg  <= c1sp_p2_reg;
        s1sp_p3_reg  <= s1sp_p2_reg;
        c1c2_p3_reg  <= c1c2_p2_reg;
        s1c2_p3_reg  <= s1c2_p2_reg;
        c1c23_p3_reg <= c1c23_p2_reg;
        s1c23_p3_reg <= s1c23_p2_reg;
        cp_p3_reg    <= cp_p2_reg;
        t2c_p3_reg   <= t2c_p2_reg;
        v_p3_reg     <= v_p2_reg;
        c1_p3_reg    <= c1_p2_reg;
        s1_p3_reg    <= s1_p2_reg;
    end

    // stage 4: base rotation products and position terms
    q_t c1e_reg, c1f_reg, s1e_reg, s1f_reg;
    q_t c1g_p4_reg, s1g_p4_reg, c1h_p4_reg, s1h_p4_reg;
    q_t r2_p4_reg, r5_p4_reg, r6_p4_reg, r7_p4_reg, r8_p4_reg;
    pacc_t px_term_reg [0:4];
    pacc_t py_term_reg [0:4];
    pacc_t pz_term_reg [0:4];

    always_ff @(posedge clk)
    begin
        c1e_reg    <= mulq(e_reg, c1_p3_reg);
        c1f_reg    <= mulq(f_reg, c1_p3_reg);
        s1e_reg    <= mulq(e_reg, s1_p3_reg);
        s1f_reg    <= mulq(f_reg, s1_p3_reg);
        c1g_p4_reg <= c1g_p3_reg;
        s1g_p4_reg <= s1g_p3_reg;
        c1h_p4_reg <= c1h_p3_reg;
        s1h_p4_reg <= s1h_p3_reg;
        r2_p4_reg  <= r2_p3_reg;
        r5_p4_reg  <= r5_p3_reg;
        r6_p4_reg  <= r6_p3_reg;
        r7_p4_reg  <= r7_p3_reg;
        r8_p4_reg  <= r8_p3_reg;

        px_term_reg[0] <= pmul(D_W'(wrist_offset_reg), c1sp_p3_reg);
        px_term_reg[1] <= -pmul(D_W'(shoulder_offset_reg), Q_W'(s1_p3_reg));
        px_term_reg[2] <= pmul(tool_d, r2_p3_reg);
        px_term_reg[3] <= pmul(D_W'(upper_arm_length_reg), c1c2_p3_reg);
        px_term_reg[4] <= pmul(D_W'(forearm_length_reg), c1c23_p3_reg);

        py_term_reg[0] <= pmul(D_W'(wrist_offset_reg), s1sp_p3_reg);
        py_term_reg[1] <= pmul(D_W'(shoulder_offset_reg), Q_W'(c1_p3_reg));
        py_term_reg[2] <= pmul(tool_d, r5_p3_reg);
        py_term_reg[3] <= pmul(D_W'(upper_arm_length_reg), s1c2_p3_reg);
        py_term_reg[4] <= pmul(D_W'(forearm_length_reg), s1c23_p3_reg);

        pz_term_reg[0] <= PACC_W'(base_height_reg) <<< TRIG_FRAC;
        pz_term_reg[1] <= pmul(D_W'(upper_arm_length_reg), Q_W'(t2c_p3_reg));
        pz_term_reg[2] <= pmul(D_W'(forearm_length_reg), Q_W'(v_p3_reg));
        pz_term_reg[3] <= pmul(D_W'(wrist_offset_reg), Q_W'(cp_p3_reg));
        pz_term_reg[4] <= pmul(tool_d, r8_p3_reg);
    end

    // stage 5: rotation sums and partial position sums
    q_t    rot_p5_reg [0:8];
    pacc_t px_lo_reg, px_hi_reg, py_lo_reg, py_hi_reg, pz_lo_reg, pz_hi_reg;

    always_ff @(posedge clk)
    begin
        rot_p5_reg[0] <= c1e_reg - s1g_p4_reg;
        rot_p5_reg[1] <= c1f_reg + s1h_p4_reg;
        rot_p5_reg[2] <= r2_p4_reg;
        rot_p5_reg[3] <= s1e_reg + c1g_p4_reg;
        rot_p5_reg[4] <= s1f_reg - c1h_p4_reg;
        rot_p5_reg[5] <= r5_p4_reg;
        rot_p5_reg[6] <= r6_p4_reg;
        rot_p5_reg[7] <= r7_p4_reg;
        rot_p5_reg[8] <= r8_p4_reg;
        px_lo_reg <= px_term_reg[0] + px_term_reg[1] + px_term_reg[2];
        px_hi_reg <= px_term_reg[3] + px_term_reg[4];
        py_lo_reg <= py_term_reg[0] + py_term_reg[1] + py_term_reg[2];
        py_hi_reg <= py_term_reg[3] + py_term_reg[4];
        pz_lo_reg <= pz_term_reg[0] + pz_term_reg[1] + pz_term_reg[2];
        pz_hi_reg <= pz_term_reg[3] + pz_term_reg[4];
    end

    // stage 6: rounding and saturation into the result registers
    logic signed [ROT_W-1:0] rot_out_reg [0:8];
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            rot_out_reg[i] <= rot_sat(rot_p5_reg[i]);
        end
        pos_x_reg <= pos_sat(px_lo_reg + px_hi_reg);
        pos_y_reg <= pos_sat(py_lo_reg + py_hi_reg);
        pos_z_reg <= pos_sat(pz_lo_reg + pz_hi_reg);
    end

    assign done   = p6_vld_reg;
    assign rot_00 = rot_out_reg[0];
    assign rot_01 = rot_out_reg[1];
    assign rot_02 = rot_out_reg[2];
    assign rot_10 = rot_out_reg[3];
    assign rot_11 = rot_out_reg[4];
    assign rot_12 = rot_out_reg[5];
    assign rot_20 = rot_out_reg[6];
    assign rot_21 = rot_out_reg[7];
    assign rot_22 = rot_out_reg[8];
    assign pos_x  = pos_x_reg;
    assign pos_y  = pos_y_reg;
    assign pos_z  = pos_z_reg;

    `AFTK_ASSERT_DELAY(a_fixed_latency, start && !busy, TOTAL_LAT, done, "result missing after start")
    `AFTK_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, TOTAL_LAT), "result without a transaction")
    `AFTK_ASSERT_IMP(a_pos_z_range, done, pos_z >= -19'sd131072 && pos_z <= 19'sd131072, "pos_z out of range")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import aftk_pkg::*;

    typedef struct {
        logic signed [JOINT_W-1:0] q [6];
    } joints_t;

    typedef struct {
        longint v [12];
    } pose_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = CORDIC_ITERATIONS_DEF + 20;
    localparam int NUM_LINKS      = 7;

    localparam longint ATAN_TAB [24] = '{
        843314856, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [JOINT_W-1:0] joint1_angle, joint2_angle, joint3_angle;
    logic signed [JOINT_W-1:0] joint4_angle, joint5_angle, joint6_angle;
    logic done;
    logic signed [ROT_W-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
    logic signed [ROT_W-1:0] rot_20, rot_21, rot_22;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    joints_t pending_joints [$];
    pose_t   expected_poses [$];
    longint  link_regs [NUM_LINKS];
    int      idle_pct;
    bit      hold_sender;
    bit      took;
    int      errors;
    int      quiet_cycles;

    arm_tool_forward_kinematics_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .joint1_angle(joint1_angle), .joint2_angle(joint2_angle),
        .joint3_angle(joint3_angle), .joint4_angle(joint4_angle),
        .joint5_angle(joint5_angle), .joint6_angle(joint6_angle),
        .done(done),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02), .pos_x(pos_x),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12), .pos_y(pos_y),
        .rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22), .pos_z(pos_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shift(a * b, TRIG_FRAC);
    endfunction

    function automatic longint clamp(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint z, x, y, nx;
        bit flip;
        z = ang * 65536;
        x = CORDIC_GAIN;
        y = 0;
        flip = 0;
        while (z > ANG_HALF_PI)
        begin
            z -= ANG_PI;
            flip = !flip;
        end
        while (z < -ANG_HALF_PI)
        begin
            z += ANG_PI;
            flip = !flip;
        end
        for (int i = 0; i < CORDIC_ITERATIONS_DEF && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TAB[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TAB[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    task automatic predict_pose(input joints_t j, output pose_t p);
        longint q [6];
        longint s1, c1, t2s, t2c, u, v, sp, cp, s5, c5, s6, c6;
        longint c2, s2, c23, s23, a, b, e, f, g, h, k, tool, px, py, pz;
        longint r [9];
        for (int i = 0; i < 6; i++)
            q[i] = j.q[i];
        sin_cos(q[0], s1, c1);
        sin_cos(q[1], t2s, t2c);
        sin_cos(q[1] + q[2], u, v);
        sin_cos(q[1] + q[2] + q[3], sp, cp);
        sin_cos(q[4], s5, c5);
        sin_cos(q[5], s6, c6);
        c2 = t2s;
        s2 = -t2c;
        c23 = u;
        s23 = -v;
        a = qmul(cp, c5);
        b = qmul(sp, c5);
        e = qmul(sp, s6) + qmul(a, c6);
        f = qmul(sp, c6) - qmul(a, s6);
        g = qmul(s5, c6);
        h = qmul(s5, s6);
        k = qmul(cp, s5);
        r[0] = qmul(c1, e) - qmul(s1, g);
        r[1] = qmul(c1, f) + qmul(s1, h);
        r[2] = qmul(c1, k) + qmul(s1, c5);
        r[3] = qmul(s1, e) + qmul(c1, g);
        r[4] = qmul(s1, f) - qmul(c1, h);
        r[5] = qmul(s1, k) - qmul(c1, c5);
        r[6] = qmul(cp, s6) - qmul(b, c6);
        r[7] = qmul(cp, c6) + qmul(b, s6);
        r[8] = -qmul(sp, s5);
        tool = link_regs[REG_FLANGE_OFFSET] + link_regs[REG_TOOL_LENGTH];
        px = round_shift(link_regs[REG_WRIST_OFFSET] * qmul(c1, sp)
                         - link_regs[REG_SHOULDER_OFFSET] * s1 + tool * r[2]
                         + link_regs[REG_UPPER_ARM] * qmul(c1, c2)
                         + link_regs[REG_FOREARM] * qmul(c1, c23), TRIG_FRAC);
        py = round_shift(link_regs[REG_WRIST_OFFSET] * qmul(s1, sp)
                         + link_regs[REG_SHOULDER_OFFSET] * c1 + tool * r[5]
                         + link_regs[REG_UPPER_ARM] * qmul(s1, c2)
                         + link_regs[REG_FOREARM] * qmul(s1, c23), TRIG_FRAC);
        pz = round_shift(link_regs[REG_BASE_HEIGHT] * 64'sd1073741824
                         - link_regs[REG_UPPER_ARM] * s2
                         - link_regs[REG_FOREARM] * s23
                         + link_regs[REG_WRIST_OFFSET] * cp + tool * r[8], TRIG_FRAC);
        for (int i = 0; i < 3; i++)
            for (int m = 0; m < 3; m++)
                p.v[i * 4 + m] = clamp(round_shift(r[i * 3 + m], ROT_SHIFT), ROT_LIMIT);
        p.v[3] = clamp(px, POS_LIMIT);
        p.v[7] = clamp(py, POS_LIMIT);
        p.v[11] = clamp(pz, POS_LIMIT);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (pending_joints.size() > 0 && !hold_sender
                && $urandom_range(99) >= idle_pct)
            begin
                joints_t j;
                j = pending_joints.pop_front();
                start <= 1'b1;
                joint1_angle <= j.q[0];
                joint2_angle <= j.q[1];
                joint3_angle <= j.q[2];
                joint4_angle <= j.q[3];
                joint5_angle <= j.q[4];
                joint6_angle <= j.q[5];
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // input capture, result check and watchdog
    always @(posedge clk)
    begin
        joints_t j;
        pose_t p, got;
        string names [12];
        names = '{"rot_00", "rot_01", "rot_02", "pos_x", "rot_10", "rot_11",
                  "rot_12", "pos_y", "rot_20", "rot_21", "rot_22", "pos_z"};
        took <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            j.q = '{joint1_angle, joint2_angle, joint3_angle,
                    joint4_angle, joint5_angle, joint6_angle};
            predict_pose(j, p);
            expected_poses.push_back(p);
        end
        if (rst_n && done)
        begin
            got.v = '{rot_00, rot_01, rot_02, pos_x, rot_10, rot_11, rot_12, pos_y,
                      rot_20, rot_21, rot_22, pos_z};
            if (expected_poses.size() == 0)
            begin
                $display("%0t unexpected transaction", $realtime);
                errors++;
            end
            else
            begin
                p = expected_poses.pop_front();
                for (int i = 0; i < 12; i++)
                    if (p.v[i] != got.v[i])
                    begin
                        $display("%0t %s expected %0d actual %0d",
                                 $realtime, names[i], p.v[i], got.v[i]);
                        errors++;
                    end
            end
        end
        if (rst_n && ((start && !busy) || done || psel))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic reg_write(input int idx, input longint value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx * 4);
        pwdata <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx < NUM_LINKS)
            link_regs[idx] = longint'($signed(CFG_W'(value)));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_joints.size() != 0 || start || expected_poses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [JOINT_W-1:0] rand_angle();
        if ($urandom_range(9) < 7)
            return JOINT_W'(int'($urandom_range(205888)) - 102944);
        return JOINT_W'($urandom);
    endfunction

    task automatic queue_random(input int n);
        joints_t j;
        for (int i = 0; i < n; i++)
        begin
            foreach (j.q[m])
                j.q[m] = rand_angle();
            pending_joints.push_back(j);
        end
    endtask

    task automatic queue_directed();
        joints_t j;
        int vals [10];
        vals = '{0, 102944, -102944, 25736, -25736, 51472, -51472,
                 131071, -131072, 1};
        foreach (vals[i])
        begin
            foreach (j.q[m])
                j.q[m] = JOINT_W'(vals[i]);
            pending_joints.push_back(j);
        end
        for (int m = 0; m < 6; m++)
        begin
            foreach (j.q[n])
                j.q[n] = '0;
            j.q[m] = JOINT_W'(25736);
            pending_joints.push_back(j);
            j.q[m] = JOINT_W'(-131072);
            pending_joints.push_back(j);
        end
    endtask

    initial
    begin
        longint rst_vals [NUM_LINKS];
        rst_vals = '{14418, 9509, -8008, 6947, 7497, 28115, 26968};
        link_regs = rst_vals;
        rst_n = 1'b0;
        start = 1'b0;
        joint1_angle = '0;
        joint2_angle = '0;
        joint3_angle = '0;
        joint4_angle = '0;
        joint5_angle = '0;
        joint6_angle = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        hold_sender = 0;
        took = 0;
        errors = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        wait_idle();

        queue_random(200);
        wait_idle();
        for (int i = 0; i < NUM_LINKS; i++)
            reg_write(i, 65536);
        reg_write(NUM_LINKS, 12345);
        queue_directed();
        idle_pct = 49;
        queue_random(200);
        wait_idle();

        for (int i = 0; i < NUM_LINKS; i++)
            reg_write(i, -65536);
        queue_random(100);
        // sender stays quiet until the pipeline has drained
        @(negedge clk);
        while (pending_joints.size() > 50)
            @(negedge clk);
        hold_sender = 1;
        while (start || expected_poses.size() != 0)
            @(negedge clk);
        hold_sender = 0;
        idle_pct = 30;
        queue_random(150);
        wait_idle();

        for (int i = 0; i < NUM_LINKS; i++)
            reg_write(i, longint'($signed(CFG_W'($urandom))));
        idle_pct = 0;
        queue_random(150);
        wait_idle();

        for (int i = 0; i < NUM_LINKS; i++)
            reg_write(i, 0);
        reg_write(REG_BASE_HEIGHT, 131071);
        reg_write(REG_FOREARM, -131072);
        idle_pct = 49;
        queue_random(100);
        wait_idle();

        for (int i = 0; i < NUM_LINKS; i++)
            reg_write(i, rst_vals[i]);
        idle_pct = 30;
        queue_random(100);
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/aftk_pkg.sv
sv/aftk_cordic.sv
sv/arm_tool_forward_kinematics_core.sv
test/tb_top.sv
